### design/svx_pkg.sv
// Shared types, constants and vertex math for the shadow volume extruder.
// No dependencies.
package svx_pkg;

  localparam int MaxTris   = 1024;
  localparam int TriW      = $clog2(MaxTris);
  localparam int RowDepth  = MaxTris * 3;
  localparam int RowAw     = $clog2(RowDepth);
  localparam int RowW      = 96;

  typedef enum logic [1:0] {
    CMD_TRI_AB = 2'd0,
    CMD_TRI_C  = 2'd1,
    CMD_EDGE   = 2'd2,
    CMD_CAP    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_POS_X = 3'd0,
    REG_POS_Y = 3'd1,
    REG_POS_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5,
    REG_DIRL  = 3'd6,
    REG_ZPASS = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CORNER_C,
    ST_EDGE_RD,
    ST_EDGE_EMIT,
    ST_CAP
  } state_t;

  // z-fail quad order, bit k = vertex k: which edge end, and extruded or not.
  // z-pass flips the end choice and keeps the extrusion pattern.
  localparam logic [5:0] EdgeUseV1 = 6'b101001;
  localparam logic [5:0] EdgeFar   = 6'b110100;

  localparam logic signed [10:0] ExtrudeScale = 11'sd1000;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   w;
  } vtx_t;

  typedef struct packed {
    vec3_t pos;
    vec3_t dir;
    logic  dirl;
    logic  zpass;
  } light_t;

  function automatic coord_t sat32(input logic signed [42:0] v);
    if (v > 43'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -43'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = coord_t'(v[31:0]);
    end
  endfunction

  function automatic coord_t far1(input coord_t v, input coord_t d, input coord_t p,
                                  input logic dirl);
    logic signed [42:0] s;
    if (dirl) begin
      s = 43'(v) + 43'(d) * ExtrudeScale;
    end else begin
      s = 43'(v) - 43'(p);
    end
    far1 = sat32(s);
  endfunction

  function automatic vtx_t make_vtx(input vec3_t v, input logic far, input light_t l);
    vtx_t r;
    if (far) begin
      r.x = far1(v.x, l.dir.x, l.pos.x, l.dirl);
      r.y = far1(v.y, l.dir.y, l.pos.y, l.dirl);
      r.z = far1(v.z, l.dir.z, l.pos.z, l.dirl);
      r.w = l.dirl;
    end else begin
      r.x = v.x;
      r.y = v.y;
      r.z = v.z;
      r.w = 1'b1;
    end
    make_vtx = r;
  endfunction

endpackage

### design/svx_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module svx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/shadow_volume_extruder.sv
// Shadow volume extruder top level: command sequencer, facing math, output register.
// Depends on svx_pkg and svx_ram.
//
// Users: a command beat is taken when start is high and busy is low; the block then
// works on that one beat alone. Triangle first half (corners a, b, normal) puts
// three 32x33 products through one multiplier, accumulated to get the facing
// sign, while the two corner rows go to the corner memory. The third corner is a
// single row write. An edge reads both facing bits from the single read port of
// the facing memory, then, if it is a silhouette, puts out its quad one vertex
// per cycle. A cap shows a vertex for each of its three corner rows as they
// stream out of the corner memory one per cycle; in z-pass mode a cap finishes
// at once and shows nothing. Each vertex is on the out_ ports for exactly one
// cycle with out_valid high; the receiver cannot stall, so take it then.
// out_last_vertex marks the final vertex of a command. Memories start undefined:
// read only triangles that were loaded. Write configuration only while busy is
// low and nothing is pending.
module shadow_volume_extruder (
  input  logic                  clk,
  input  logic                  rst_n,
  // command beat
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_cmd,
  input  svx_pkg::coord_t       in_px,
  input  svx_pkg::coord_t       in_py,
  input  svx_pkg::coord_t       in_pz,
  input  svx_pkg::coord_t       in_qx,
  input  svx_pkg::coord_t       in_qy,
  input  svx_pkg::coord_t       in_qz,
  input  svx_pkg::coord_t       in_nx,
  input  svx_pkg::coord_t       in_ny,
  input  svx_pkg::coord_t       in_nz,
  input  logic [9:0]            in_tri_first,
  input  logic signed [10:0]    in_tri_second,
  // result beat
  output logic                  out_valid,
  output svx_pkg::coord_t       out_x,
  output svx_pkg::coord_t       out_y,
  output svx_pkg::coord_t       out_z,
  output logic                  out_w,
  output logic                  out_last_vertex,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  import svx_pkg::*;

  // configuration registers
  light_t light_r;

  // item registers
  state_t            state_r, state_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  cmd_t              cmd_r;
  vec3_t             p_r, q_r, n_r;
  logic [TriW-1:0]   t0_r;
  logic signed [10:0] t1_r;
  logic              f0_r;

  // facing arithmetic
  logic signed [64:0] prod_r;
  logic signed [66:0] acc_r;
  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;

  // memory ports
  logic              f_we, f_wdata, f_rdata;
  logic [TriW-1:0]   f_waddr, f_raddr;
  logic              c_we;
  logic [RowAw-1:0]  c_waddr, c_raddr, row_base;
  logic [RowW-1:0]   c_wdata, c_rdata;

  // emission
  logic              emit, emit_last, emit_far, use_q, cap_face;
  vec3_t             emit_v;
  vtx_t              emit_vtx;

  logic              accept;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign row_base  = RowAw'({t0_r, 1'b0}) + RowAw'(t0_r);

  svx_ram #(.WIDTH(1), .DEPTH(MaxTris)) u_facing (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  svx_ram #(.WIDTH(RowW), .DEPTH(RowDepth)) u_corner (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // next state and step counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 3'd1;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          case (cmd_t'(in_cmd))
            CMD_TRI_AB: state_nxt = ST_LOAD;
            CMD_TRI_C:  state_nxt = ST_CORNER_C;
            CMD_EDGE:   state_nxt = ST_EDGE_RD;
            CMD_CAP:    state_nxt = light_r.zpass ? ST_IDLE : ST_CAP;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        if (cnt_r == 3'd4) state_nxt = ST_IDLE;
      end
      ST_CORNER_C: begin
        state_nxt = ST_IDLE;
      end
      ST_EDGE_RD: begin
        if (cnt_r == 3'd2) begin
          cnt_nxt = '0;
          // open boundary: silhouette when the first triangle faces the light
          if (t1_r[10] ? f0_r : (f0_r != f_rdata)) begin
            state_nxt = ST_EDGE_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EDGE_EMIT: begin
        if (cnt_r == 3'd5) state_nxt = ST_IDLE;
      end
      ST_CAP: begin
        if (cnt_r == 3'd3) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath controls per state
  always_comb begin
    f_we      = 1'b0;
    f_waddr   = t0_r;
    f_wdata   = (acc_r > 67'sd0);
    f_raddr   = t0_r;
    c_we      = 1'b0;
    c_waddr   = row_base;
    c_wdata   = p_r;
    c_raddr   = row_base;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_far  = 1'b0;
    use_q     = 1'b0;
    cap_face  = f0_r;
    emit_v    = p_r;
    case (state_r)
      ST_LOAD: begin
        // corner a then corner b, facing bit once all products are summed
        case (cnt_r)
          3'd0: c_we = 1'b1;
          3'd1: begin
            c_we    = 1'b1;
            c_waddr = row_base + RowAw'(1);
            c_wdata = q_r;
          end
          3'd4: f_we = 1'b1;
          default: c_we = 1'b0;
        endcase
      end
      ST_CORNER_C: begin
        c_we    = 1'b1;
        c_waddr = row_base + RowAw'(2);
      end
      ST_EDGE_RD: begin
        if (cnt_r != 3'd0) f_raddr = TriW'(t1_r[9:0]);
      end
      ST_EDGE_EMIT: begin
        emit      = 1'b1;
        emit_last = (cnt_r == 3'd5);
        emit_far  = EdgeFar[cnt_r];
        // v1 is q when the first triangle faces the light
        use_q     = (EdgeUseV1[cnt_r] ^ light_r.zpass) == f0_r;
        emit_v    = use_q ? q_r : p_r;
      end
      ST_CAP: begin
        c_raddr   = row_base + RowAw'(cnt_r);
        emit      = (cnt_r != 3'd0);
        emit_last = (cnt_r == 3'd3);
        cap_face  = (cnt_r == 3'd1) ? f_rdata : f0_r;
        emit_far  = !cap_face;
        emit_v    = c_rdata;
      end
      default: emit = 1'b0;
    endcase
  end

  assign emit_vtx = make_vtx(emit_v, emit_far, light_r);

  // one product of the facing dot product per step
  always_comb begin
    case (cnt_r)
      3'd0: begin
        mul_a = n_r.x;
        mul_b = light_r.dirl ? -33'(light_r.dir.x) : 33'(light_r.pos.x) - 33'(p_r.x);
      end
      3'd1: begin
        mul_a = n_r.y;
        mul_b = light_r.dirl ? -33'(light_r.dir.y) : 33'(light_r.pos.y) - 33'(p_r.y);
      end
      default: begin
        mul_a = n_r.z;
        mul_b = light_r.dirl ? -33'(light_r.dir.z) : 33'(light_r.pos.z) - 33'(p_r.z);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      out_valid <= 1'b0;
      light_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_valid <= emit;
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_POS_X: light_r.pos.x <= cfg_data;
          REG_POS_Y: light_r.pos.y <= cfg_data;
          REG_POS_Z: light_r.pos.z <= cfg_data;
          REG_DIR_X: light_r.dir.x <= cfg_data;
          REG_DIR_Y: light_r.dir.y <= cfg_data;
          REG_DIR_Z: light_r.dir.z <= cfg_data;
          REG_DIRL:  light_r.dirl  <= cfg_data[0];
          REG_ZPASS: light_r.zpass <= cfg_data[0];
          default:   light_r.zpass <= light_r.zpass;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(in_cmd);
      p_r   <= '{in_px, in_py, in_pz};
      q_r   <= '{in_qx, in_qy, in_qz};
      n_r   <= '{in_nx, in_ny, in_nz};
      t0_r  <= in_tri_first;
      t1_r  <= in_tri_second;
    end
    // hold the first facing bit for edges and caps
    if ((state_r == ST_EDGE_RD || state_r == ST_CAP) && cnt_r == 3'd1) begin
      f0_r <= f_rdata;
    end
    prod_r <= 65'(mul_a) * 65'(mul_b);
    if (cnt_r == 3'd0) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_r + 67'(prod_r);
    end
    out_x           <= emit_vtx.x;
    out_y           <= emit_vtx.y;
    out_z           <= emit_vtx.z;
    out_w           <= emit_vtx.w;
    out_last_vertex <= emit_last;
  end

  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_EDGE_EMIT || $past(state_r) == ST_CAP))
    else $error("vertex beat outside an emitting state");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_vertex) |-> (state_r == ST_IDLE))
    else $error("last vertex shown while still busy");

  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !out_valid)
    else $error("vertex beat right after accept");

  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD || state_r == ST_CORNER_C) |=> !out_valid)
    else $error("triangle load produced a vertex");

  a_cap_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CAP) |-> (cmd_r == CMD_CAP && !light_r.zpass))
    else $error("cap sequence without a z-fail cap command");

endmodule
